[sv/sdvf_pkg.sv]
// package for the speed dependent viscous force block
// widths, register indexes, sequencer states and fixed point helpers; no dependencies
package sdvf_pkg;

  localparam int FracBitsDefault = 16;
  localparam int AxisBits        = 14;

  // configuration register indexes
  localparam logic [2:0] REG_SPEED_LOW   = 3'd0;
  localparam logic [2:0] REG_SPEED_HIGH  = 3'd1;
  localparam logic [2:0] REG_DAMP_MIN    = 3'd2;
  localparam logic [2:0] REG_DAMP_MAX    = 3'd3;
  localparam logic [2:0] REG_TAU         = 3'd4;
  localparam logic [2:0] REG_LEVER_LIMIT = 3'd5;

  // control point codes
  localparam logic [1:0] POINT_B = 2'd0;
  localparam logic [1:0] POINT_T = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,        // sum of squares, one product per cycle
    S_SQRT,      // square root, one result bit per cycle
    S_INTERP,    // interpolation product
    S_IDIV,      // interpolation divide, one quotient bit per cycle
    S_BSEL,      // target damping
    S_FMUL,      // filter product
    S_FDIV,      // filter divide
    S_FUPD,      // filter update
    S_ADIV,      // lever ratio divide
    S_ALPHA,     // lever ratio clamp
    S_DOT,       // z.v, one term per cycle
    S_PSAT,
    S_U,         // u_i = z_i * p
    S_W,         // alpha*v_i and beta*u_i
    S_WSUM,
    S_FORCE,     // b * w2_i
    S_OUT
  } state_t;

  // saturate a 66 bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

[sv/sdvf_if.sv]
// valid/ready channel with a generic payload
// depends on nothing
interface sdvf_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[sv/speed_dependent_viscous_force.sv]
// Speed dependent viscous force. One item is worked at a time by a sequencer
// around one shared 34x34 multiplier and a restoring divider/root unit that
// produces one bit per cycle. A tick with a trocar passes through the sum of
// squares and the square root, then the interpolation divide and select when the
// speed lies on the damping ramp, the filter divide and update unless elapsed
// time and tau are both zero, the lever ratio divide and clamp for points B and
// T with a nonzero PF, the two lever passes, the force products and single steps
// in between. A tick without trocar goes straight to the output step. The next
// tick is taken in the cycle after the result is loaded; the result sits in an
// output register, so work goes on while it waits, and only a second finished
// result stalls until the register frees.
// depends on sdvf_pkg and sdvf_if
module speed_dependent_viscous_force
  import sdvf_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic clk,
  input  logic rst,
  sdvf_if.sink   in_ch,
  sdvf_if.source out_ch,
  sdvf_if.sink   cfg
);

  // configuration
  logic [30:0] speed_low, speed_high, damping_min, damping_max, lever_limit;
  logic [23:0] filter_tau_us;
  logic signed [31:0] filtered_damping;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_low     <= 31'd655;
      speed_high    <= 31'd6554;
      damping_min   <= 31'd0;
      damping_max   <= 31'd655360;
      filter_tau_us <= 24'd100000;
      lever_limit   <= 31'd327680;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_SPEED_LOW:   speed_low     <= cfg.data.value[30:0];
        REG_SPEED_HIGH:  speed_high    <= cfg.data.value[30:0];
        REG_DAMP_MIN:    damping_min   <= cfg.data.value[30:0];
        REG_DAMP_MAX:    damping_max   <= cfg.data.value[30:0];
        REG_TAU:         filter_tau_us <= cfg.data.value[23:0];
        REG_LEVER_LIMIT: lever_limit   <= cfg.data.value[30:0];
        default: ;
      endcase
    end
  end

  // item registers
  state_t state;
  logic signed [31:0] v [3];
  logic signed [31:0] w [3];
  logic signed [15:0] z [3];
  logic [23:0] bf, ft, pf;
  logic [1:0]  sel;
  logic [19:0] dt;
  logic [1:0]  idx;
  logic        pass;       // second application of the lever map
  logic [6:0]  cnt;
  // shared serial divide/root unit
  logic [65:0] rem;
  logic [63:0] num;
  logic [63:0] quo;
  logic [63:0] den;
  logic [65:0] acc;
  logic signed [67:0] prod;
  logic signed [33:0] ma, mb;
  logic signed [31:0] alpha, p;
  logic diff_neg;
  logic out_valid;
  logic out_load;
  logic signed [31:0] fx, fy, fz;
  logic [30:0] damping_out;

  assign prod = ma * mb;
  assign in_ch.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;
  assign out_ch.data.force_x = fx;
  assign out_ch.data.force_y = fy;
  assign out_ch.data.force_z = fz;
  assign out_ch.data.damping_now = damping_out;

  // trial subtract of the divide and root steps
  logic [65:0] rem_sh, trial_d, trial_r;
  assign rem_sh  = {rem[64:0], num[63]};
  assign trial_d = rem_sh - {2'b0, den};
  logic [65:0] rem_r;
  assign rem_r   = {rem[63:0], num[63:62]};
  assign trial_r = rem_r - {quo[63:0], 2'b01};

  // operand selection for the shared multiplier
  logic signed [33:0] beta;
  assign beta = (34'sd1 <<< FRAC_BITS) - 34'(alpha);
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_SQ:     begin ma = 34'(v[idx]); mb = 34'(v[idx]); end
      S_INTERP, S_IDIV: begin ma = 34'(acc[31:0]); mb = 34'(rem[31:0]); end
      S_FMUL:   begin ma = acc[32] ? -34'($signed(acc[32:0])) : 34'(acc[32:0]);
                      mb = 34'({12'b0, dt}); end
      S_DOT:    begin ma = 34'(z[idx]); mb = 34'(w[idx]); end
      S_U:      begin ma = 34'(z[idx]); mb = 34'(p); end
      S_W:      begin ma = cnt[0] ? beta : 34'(alpha);
                      mb = cnt[0] ? 34'($signed(acc[31:0])) : 34'(w[idx]); end
      S_FORCE:  begin ma = 34'(filtered_damping); mb = 34'(w[idx]); end
      default: ;
    endcase
  end

  // sequencer
  logic [30:0] dmag;
  logic        down;
  assign down = damping_max >= damping_min;
  assign dmag = down ? damping_max - damping_min : damping_min - damping_max;
  logic signed [65:0] wsum;
  assign wsum = 66'($signed(rem[31:0])) + 66'(sat32(66'(prod) >>> FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      filtered_damping <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          v[0] <= in_ch.data.vel_x; v[1] <= in_ch.data.vel_y; v[2] <= in_ch.data.vel_z;
          z[0] <= in_ch.data.axis_x; z[1] <= in_ch.data.axis_y; z[2] <= in_ch.data.axis_z;
          bf <= in_ch.data.dist_bf; ft <= in_ch.data.dist_ft; pf <= in_ch.data.dist_pf;
          sel <= in_ch.data.point_select; dt <= in_ch.data.elapsed_us;
          idx <= '0; acc <= '0;
          if (in_ch.data.trocar_found) state <= S_SQ;
          else begin
            w[0] <= '0; w[1] <= '0; w[2] <= '0;
            state <= S_OUT;
          end
        end
        S_SQ: begin
          acc <= acc + 66'(prod[63:0]);
          if (idx == 2'd2) begin
            num <= acc[63:0] + prod[63:0];
            rem <= '0; quo <= '0; cnt <= 7'd32;
            state <= S_SQRT;
          end else idx <= idx + 2'd1;
        end
        S_SQRT: begin
          num <= {num[61:0], 2'b00};
          if (!trial_r[65]) begin rem <= trial_r; quo <= {quo[62:0], 1'b1}; end
          else begin rem <= rem_r; quo <= {quo[62:0], 1'b0}; end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_INTERP;
        end
        S_INTERP: begin
          // quo holds the speed
          if (quo < 64'(speed_low)) begin
            state <= S_FMUL;
            acc <= 66'(33'({1'b0, damping_max}) - 33'(filtered_damping));
          end else if (quo > 64'(speed_high) || speed_high == speed_low) begin
            acc <= 66'(33'((quo > 64'(speed_high)) ? {1'b0, damping_min}
                     : {1'b0, damping_max}) - 33'(filtered_damping));
            state <= S_FMUL;
          end else begin
            acc <= 66'(dmag); rem <= 66'(quo[31:0] - 32'(speed_low));
            state <= S_IDIV;
            cnt <= 7'd0;
          end
        end
        S_IDIV: begin
          if (cnt == 7'd0) begin
            num <= prod[63:0]; den <= 64'(speed_high - speed_low);
            rem <= '0; cnt <= 7'd64;
          end else begin
            num <= {num[62:0], 1'b0};
            if (!trial_d[65]) begin rem <= trial_d; quo <= {quo[62:0], 1'b1}; end
            else begin rem <= rem_sh; quo <= {quo[62:0], 1'b0}; end
            cnt <= cnt - 7'd1;
            if (cnt == 7'd1) state <= S_BSEL;
          end
        end
        S_BSEL: begin
          acc <= 66'($signed(33'(down ? 32'({1'b0, damping_max}) - quo[31:0]
                     : 32'({1'b0, damping_max}) + quo[31:0]) - 33'(filtered_damping)));
          state <= S_FMUL;
        end
        S_FMUL: begin
          // acc holds diff; the multiplier gives its magnitude times dt
          diff_neg <= acc[32];
          if (25'(dt) + 25'(filter_tau_us) == 25'd0) state <= S_ADIV;
          else begin
            num <= prod[63:0];
            den <= 64'(dt) + 64'(filter_tau_us);
            rem <= '0; cnt <= 7'd64;
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          num <= {num[62:0], 1'b0};
          if (!trial_d[65]) begin rem <= trial_d; quo <= {quo[62:0], 1'b1}; end
          else begin rem <= rem_sh; quo <= {quo[62:0], 1'b0}; end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_FUPD;
        end
        S_FUPD: begin
          filtered_damping <= diff_neg ? filtered_damping - quo[31:0]
                                       : filtered_damping + quo[31:0];
          state <= S_ADIV;
          cnt <= 7'd0;
        end
        S_ADIV: begin
          if (sel != POINT_B && sel != POINT_T) begin
            alpha <= (33'(lever_limit) < (33'd1 << FRAC_BITS)) ? {1'b0, lever_limit}
                                                              : (32'sd1 <<< FRAC_BITS);
            state <= S_DOT; idx <= '0; acc <= '0; pass <= 1'b0;
            w <= v;
          end else if (pf == 24'd0) begin
            quo <= 64'(lever_limit); state <= S_ALPHA;
          end else if (cnt == 7'd0) begin
            num <= 64'(sel == POINT_B ? bf : ft) << FRAC_BITS;
            den <= 64'(pf); rem <= '0; cnt <= 7'd64;
          end else begin
            num <= {num[62:0], 1'b0};
            if (!trial_d[65]) begin rem <= trial_d; quo <= {quo[62:0], 1'b1}; end
            else begin rem <= rem_sh; quo <= {quo[62:0], 1'b0}; end
            cnt <= cnt - 7'd1;
            if (cnt == 7'd1) state <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (quo > 64'(lever_limit)) alpha <= (sel == POINT_B) ? {1'b0, lever_limit}
                                                                : -{1'b0, lever_limit};
          else alpha <= (sel == POINT_B) ? quo[31:0] : -quo[31:0];
          state <= S_DOT; idx <= '0; acc <= '0; pass <= 1'b0;
          w <= v;
        end
        S_DOT: begin
          acc <= acc + 66'(prod[65:0]);
          if (idx == 2'd2) state <= S_PSAT;
          else idx <= idx + 2'd1;
        end
        S_PSAT: begin
          p <= sat32($signed(acc + 66'(prod) - 66'(prod)) >>> AxisBits);
          idx <= '0; cnt <= '0;
          state <= S_U;
        end
        S_U: begin
          acc <= 66'(sat32(66'(prod) >>> AxisBits));
          cnt <= '0;
          state <= S_W;
        end
        S_W: begin
          if (!cnt[0]) begin
            rem <= 66'(sat32(66'(prod) >>> FRAC_BITS));
            cnt <= 7'd1;
          end else begin
            quo[31:0] <= sat32(wsum);
            state <= S_WSUM;
          end
        end
        S_WSUM: begin
          num[32*idx[0] +: 32] <= quo[31:0];
          if (idx == 2'd2) begin
            // all three new components ready
            w[0] <= num[31:0]; w[1] <= num[63:32]; w[2] <= quo[31:0];
            idx <= '0; acc <= '0;
            if (pass) state <= S_FORCE;
            else begin pass <= 1'b1; state <= S_DOT; end
          end else begin
            idx <= idx + 2'd1; state <= S_U;
          end
        end
        S_FORCE: begin
          // force component replaces the lever output it was made from
          w[idx] <= sat32(-(66'(prod) >>> FRAC_BITS));
          if (idx == 2'd2) state <= S_OUT;
          else idx <= idx + 2'd1;
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded when empty or when its result transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid   <= 1'b1;
      fx          <= w[0];
      fy          <= w[1];
      fz          <= w[2];
      damping_out <= filtered_damping[30:0];
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // a waiting result holds still until it transfers
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable({fx, fy, fz, damping_out}))
    else $error("pending result changed before transfer");
  // filter state moves only in its update step
  a_filter_hold: assert property (@(posedge clk) disable iff (rst)
    $past(state) != S_FUPD && !$past(rst) |-> $stable(filtered_damping))
    else $error("filtered damping changed outside update");
  // the result is shown only after a finished item
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT || $past(state) == S_IDLE)
    else $error("result raised from a working state");

endmodule

[test/sdvf_tb_pkg.sv]
`timescale 1ns / 100ps
// transfer layouts of the force input, force result and register write channels
// depends on sdvf_pkg
package sdvf_tb_pkg;
  import sdvf_pkg::*;

  typedef struct packed {
    logic               trocar_found;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [23:0]        dist_bf;
    logic [23:0]        dist_ft;
    logic [23:0]        dist_pf;
    logic [1:0]         point_select;
    logic [19:0]        elapsed_us;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [30:0]        damping_now;
  } force_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } reg_wr_t;

  localparam logic [1:0] POINT_P = 2'd2;
  localparam logic [1:0] POINT_X = 2'd3;
endpackage

[test/sdvf_checker.sv]
`timescale 1ns / 100ps
// watches the tick, force and register channels, predicts each force result and compares
// depends on sdvf_pkg and sdvf_tb_pkg
module sdvf_checker
  import sdvf_pkg::*;
  import sdvf_tb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    tick_valid,
  input  logic    tick_ready,
  input  tick_t   tick_data,
  input  logic    force_valid,
  input  logic    force_ready,
  input  force_t  force_data,
  input  logic    reg_valid,
  input  logic    reg_ready,
  input  reg_wr_t reg_data,
  output int      errors,
  output int      pending,
  output int      checked
);
  localparam int FB = 16;
  localparam int AB = 14;

  longint unsigned spd_lo, spd_hi, damp_lo, damp_hi, tau_us, lev_lim;
  longint          damp_state;
  force_t          force_q[$];

  function automatic longint sat(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned root(input longint unsigned x);
    longint unsigned rem, res, b;
    rem = x; res = 0; b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // w = alpha*v + (1-alpha)*z*(z.v)
  function automatic void lever(input longint alpha, input longint z[3], input longint v[3],
                                output longint w[3]);
    longint beta, p, u;
    beta = (64'sd1 <<< FB) - alpha;
    p = sat((z[0] * v[0] + z[1] * v[1] + z[2] * v[2]) >>> AB);
    for (int i = 0; i < 3; i++) begin
      u = sat((z[i] * p) >>> AB);
      w[i] = sat(sat((alpha * v[i]) >>> FB) + sat((beta * u) >>> FB));
    end
  endfunction

  function automatic force_t predict_force(input tick_t t);
    force_t r;
    longint v[3], z[3], w1[3], w2[3];
    longint b, alpha, mag, diff;
    longint unsigned spd, span, dm, num, den, dmag;
    r = '0;
    if (!t.trocar_found) begin
      r.damping_now = damp_state[30:0];
      return r;
    end
    v[0] = t.vel_x; v[1] = t.vel_y; v[2] = t.vel_z;
    z[0] = t.axis_x; z[1] = t.axis_y; z[2] = t.axis_z;
    // sum of squares wraps at 64 bits
    spd = root(longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]));
    // target damping from speed
    if (spd < spd_lo) b = damp_hi;
    else if (spd > spd_hi) b = damp_lo;
    else begin
      span = spd_hi - spd_lo;
      if (span == 0) b = damp_hi;
      else if (damp_hi >= damp_lo) begin
        dm = (damp_hi - damp_lo) * (spd - spd_lo) / span;
        b = longint'(damp_hi) - longint'(dm);
      end else begin
        dm = (damp_lo - damp_hi) * (spd - spd_lo) / span;
        b = longint'(damp_hi) + longint'(dm);
      end
    end
    // low-pass filter, correction truncated toward zero
    den = t.elapsed_us + tau_us;
    if (den != 0) begin
      diff = b - damp_state;
      dmag = longint'(diff < 0 ? -diff : diff) * t.elapsed_us / den;
      damp_state = diff < 0 ? damp_state - longint'(dmag) : damp_state + longint'(dmag);
    end
    b = damp_state;
    // lever ratio
    if (t.point_select == POINT_B || t.point_select == POINT_T) begin
      num = t.point_select == POINT_B ? t.dist_bf : t.dist_ft;
      mag = t.dist_pf == 0 ? longint'(lev_lim) : longint'((num << FB) / t.dist_pf);
      if (mag > longint'(lev_lim)) mag = lev_lim;
      alpha = t.point_select == POINT_B ? mag : -mag;
    end else begin
      alpha = 64'sd1 <<< FB;
      if (alpha > longint'(lev_lim)) alpha = lev_lim;
    end
    lever(alpha, z, v, w1);
    lever(alpha, z, w1, w2);
    r.force_x = 32'(sat(-((b * w2[0]) >>> FB)));
    r.force_y = 32'(sat(-((b * w2[1]) >>> FB)));
    r.force_z = 32'(sat(-((b * w2[2]) >>> FB)));
    r.damping_now = damp_state[30:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0d expected %0d", what, $time, got, want);
    errors++;
  endtask

  assign pending = force_q.size();

  always @(posedge clk) begin
    force_t want;
    if (rst) begin
      spd_lo = 655; spd_hi = 6554; damp_lo = 0; damp_hi = 655360;
      tau_us = 100000; lev_lim = 327680; damp_state = 0;
      force_q.delete();
      errors = 0; checked = 0;
    end else begin
      // register write transfer
      if (reg_valid && reg_ready) begin
        case (reg_data.index)
          REG_SPEED_LOW:   spd_lo  = reg_data.value[30:0];
          REG_SPEED_HIGH:  spd_hi  = reg_data.value[30:0];
          REG_DAMP_MIN:    damp_lo = reg_data.value[30:0];
          REG_DAMP_MAX:    damp_hi = reg_data.value[30:0];
          REG_TAU:         tau_us  = reg_data.value[23:0];
          REG_LEVER_LIMIT: lev_lim = reg_data.value[30:0];
          default: ;
        endcase
      end
      // tick transfer
      if (tick_valid && tick_ready) force_q.push_back(predict_force(tick_data));
      // force transfer
      if (force_valid && force_ready) begin
        if (force_q.size() == 0) begin
          $display("unexpected force result at %0t", $time);
          errors++;
        end else begin
          want = force_q.pop_front();
          checked++;
          if (force_data.force_x !== want.force_x)
            report("force_x", force_data.force_x, want.force_x);
          if (force_data.force_y !== want.force_y)
            report("force_y", force_data.force_y, want.force_y);
          if (force_data.force_z !== want.force_z)
            report("force_z", force_data.force_z, want.force_z);
          if (force_data.damping_now !== want.damping_now)
            report("damping_now", force_data.damping_now, want.damping_now);
        end
      end
    end
  end
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// drives ticks and register writes into the viscous force block and gives the verdict
// depends on sdvf_pkg, sdvf_if, sdvf_tb_pkg, sdvf_checker and the block itself
module tb_top;
  import sdvf_pkg::*;
  import sdvf_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, checked, sent;

  sdvf_if #(.payload_t(tick_t))   in_ch(clk);
  sdvf_if #(.payload_t(force_t))  out_ch(clk);
  sdvf_if #(.payload_t(reg_wr_t)) cfg(clk);

  speed_dependent_viscous_force DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  sdvf_checker chk (
    .clk(clk), .rst(rst),
    .tick_valid(in_ch.valid), .tick_ready(in_ch.ready), .tick_data(in_ch.data),
    .force_valid(out_ch.valid), .force_ready(out_ch.ready), .force_data(out_ch.data),
    .reg_valid(cfg.valid), .reg_ready(cfg.ready), .reg_data(cfg.data),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15ms;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    int wait_cyc, n;
    out_ch.ready = 1'b0;
    n = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cyc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ((n / 100) % 2 == 1) wait_cyc = 0;
      if (n == 60) wait_cyc = 3000;
      if (wait_cyc > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cyc) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      n++;
      @(negedge clk);
    end
  end

  task automatic send_tick(input tick_t t);
    int gap;
    gap = ((sent / 90) % 3 == 2) ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= '{index: idx, value: val};
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // let every result drain before touching registers
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] lo, hi, dmin, dmax, tau, lim);
    write_reg(REG_SPEED_LOW, lo);
    write_reg(REG_SPEED_HIGH, hi);
    write_reg(REG_DAMP_MIN, dmin);
    write_reg(REG_DAMP_MAX, dmax);
    write_reg(REG_TAU, tau);
    write_reg(REG_LEVER_LIMIT, lim);
  endtask

  function automatic tick_t mk(input logic tf, input logic [31:0] vx, vy, vz,
                               input logic [15:0] ax, ay, az,
                               input logic [23:0] bf, ft, pf,
                               input logic [1:0] sel, input logic [19:0] dt);
    return '{tf, vx, vy, vz, ax, ay, az, bf, ft, pf, sel, dt};
  endfunction

  function automatic logic [15:0] rnd_axis();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // mostly well-formed ticks with speeds near the damping ramp, some noise
  function automatic tick_t rnd_tick();
    tick_t t;
    logic [15:0] unit;
    t.trocar_found = $urandom_range(0, 9) != 0;
    case ($urandom_range(0, 3))
      0: begin
        t.vel_x = $urandom; t.vel_y = $urandom; t.vel_z = $urandom;
      end
      1: begin
        t.vel_x = $signed($urandom_range(0, 16000)) - 8000;
        t.vel_y = $signed($urandom_range(0, 16000)) - 8000;
        t.vel_z = $signed($urandom_range(0, 16000)) - 8000;
      end
      default: begin
        t.vel_x = $signed($urandom_range(0, 2000000)) - 1000000;
        t.vel_y = $signed($urandom_range(0, 2000000)) - 1000000;
        t.vel_z = $signed($urandom_range(0, 2000000)) - 1000000;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      t.axis_x = rnd_axis(); t.axis_y = rnd_axis(); t.axis_z = rnd_axis();
    end else begin
      unit = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      t.axis_x = 0; t.axis_y = 0; t.axis_z = 0;
      case ($urandom_range(0, 2))
        0: t.axis_x = unit;
        1: t.axis_y = unit;
        default: t.axis_z = unit;
      endcase
    end
    t.dist_bf = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
    t.dist_ft = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
    t.dist_pf = $urandom_range(0, 9) == 0 ? 24'd0 : 24'($urandom);
    t.point_select = $urandom_range(0, 7) == 0 ? POINT_X : 2'($urandom_range(0, 2));
    t.elapsed_us = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 2000));
    return t;
  endfunction

  initial begin
    logic [31:0] a, b;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg.valid   = 1'b0;
    cfg.data    = '0;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset registers, field extremes, every control point, special cases
    send_tick(mk(1, 0, 0, 0, 16384, 0, 0, 0, 0, 0, POINT_B, 0));
    send_tick(mk(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 16384, 16384,
                 24'hffffff, 24'hffffff, 1, POINT_B, 20'hfffff));
    send_tick(mk(1, 32'h80000000, 32'h80000000, 32'h80000000, -16384, -16384, -16384,
                 24'hffffff, 24'hffffff, 24'hffffff, POINT_T, 20'hfffff));
    send_tick(mk(1, 1000, -2000, 3000, 0, 0, 16384, 65536, 131072, 0, POINT_B, 1000));
    send_tick(mk(1, 1000, -2000, 3000, 0, 0, 16384, 65536, 131072, 0, POINT_T, 1000));
    send_tick(mk(1, 100, 200, 300, 0, 16384, 0, 65536, 65536, 65536, POINT_P, 500));
    send_tick(mk(1, 100, 200, 300, 0, 16384, 0, 65536, 65536, 65536, POINT_X, 500));
    send_tick(mk(0, 5000, 5000, 5000, 16384, 0, 0, 1, 1, 1, POINT_B, 1000));
    send_tick(mk(1, 3000, 0, 0, 11585, 11585, 0, 98304, 32768, 65536, POINT_B, 100000));
    send_tick(mk(1, 0, 4000, 0, 0, 0, -16384, 32768, 98304, 65536, POINT_T, 0));
    send_tick(mk(1, 1 << 20, -(1 << 20), 1 << 20, 16384, 16384, 0, 24'hffffff, 0, 2,
                 POINT_B, 50));
    send_tick(mk(1, 654, 0, 0, 0, 0, 16384, 65536, 65536, 65536, POINT_P, 10000));
    send_tick(mk(1, 6554, 0, 0, 0, 0, 16384, 65536, 65536, 65536, POINT_P, 10000));
    send_tick(mk(1, 6555, 0, 0, 0, 0, 16384, 65536, 65536, 65536, POINT_P, 10000));
    drain();

    // empty speed span and zero lever limit
    set_regs(5000, 5000, 100, 900000, 1, 0);
    send_tick(mk(1, 5000, 0, 0, 16384, 0, 0, 65536, 65536, 65536, POINT_B, 10));
    send_tick(mk(1, 4999, 0, 0, 16384, 0, 0, 65536, 65536, 65536, POINT_P, 10));
    send_tick(mk(1, 5001, 0, 0, 16384, 0, 0, 65536, 65536, 65536, POINT_T, 10));
    drain();
    // reversed speeds, rising damping, widest registers
    set_regs(32'h7fffffff, 0, 32'h7fffffff, 0, 24'hffffff, 32'h7fffffff);
    send_tick(mk(1, 10, 0, 0, 16384, 0, 0, 24'hffffff, 0, 1, POINT_B, 20'hfffff));
    send_tick(mk(1, 32'h7fffffff, 0, 0, 0, 16384, 0, 24'hffffff, 24'hffffff, 1, POINT_T,
                 20'hfffff));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(655, 6554, 0, 655360, 100000, 327680);
        1: set_regs(0, 32'h7fffffff, 0, 32'h7fffffff, 1, 32'h7fffffff);
        2: set_regs(2000, 3000000, 900000, 100, 5000, 65536);
        3: set_regs(1000000, 10, 50000, 1000000, 200, 1 << 20);
        default: begin
          a = $urandom_range(0, 100000);
          b = a + $urandom_range(0, 2000000);
          set_regs(a, b, $urandom & 32'h000fffff, $urandom & 32'h7fffffff,
                   $urandom_range(1, 24'hffffff), $urandom & 32'h7fffffff);
        end
      endcase
      repeat (120) send_tick(rnd_tick());
      drain();
    end

    $display("ran %0d ticks over nine register settings, %0d force results compared",
             sent, checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
